// ===== design/lbs_pkg.sv =====
package lbs_pkg;

  localparam int WORD_W    = 32;
  localparam int MAT_WORDS = 12;
  localparam int LANE_MAX  = 4;
  localparam int PROD_W    = 64;
  localparam int XSUM_W    = 67;
  localparam int WGT_W     = 16;
  localparam int WPROD_W   = 48;
  localparam int MSUM_W    = 51;
  localparam int RND_Q16   = 32768;
  localparam int RND_Q15   = 16384;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_DIR   = 2'd2;

  typedef struct packed {
    logic [1:0]               operation;
    logic [6:0]               matrix_slot;
    logic [3:0]               matrix_element;
    logic signed [WORD_W-1:0] in_x;
    logic signed [WORD_W-1:0] in_y;
    logic signed [WORD_W-1:0] in_z;
    logic [31:0]              joint_ids;
    logic [63:0]              joint_weight_set;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_x;
    logic signed [WORD_W-1:0] out_y;
    logic signed [WORD_W-1:0] out_z;
    logic                     joint_fault;
  } rsp_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < 64'shFFFF_FFFF_8000_0000) return 32'sh8000_0000;
    return 32'(x);
  endfunction

endpackage

// ===== design/lbs_xform.sv =====
module lbs_xform (
  input  logic                                clk_i,
  input  logic                                prod_en_i,
  input  logic                                sum_en_i,
  input  logic                                with_t_i,
  input  logic signed [lbs_pkg::WORD_W-1:0]   mat_i [lbs_pkg::MAT_WORDS],
  input  logic signed [lbs_pkg::WORD_W-1:0]   vec_i [3],
  output logic signed [lbs_pkg::WORD_W-1:0]   res_o [3]
);
  import lbs_pkg::*;

  logic signed [PROD_W-1:0] prod_q [3][3];
  logic signed [WORD_W-1:0] tr_q [3];
  logic signed [XSUM_W-1:0] sum_d [3];
  logic signed [WORD_W-1:0] res_d [3];
  logic signed [WORD_W-1:0] res_q [3];

  // one product per word of the 3x3 part, translation row held beside them
  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_q[c][r] <= mat_i[3*r+c] * vec_i[r];
        end
        tr_q[c] <= with_t_i ? mat_i[9+c] : '0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = XSUM_W'(prod_q[c][0]) + XSUM_W'(prod_q[c][1]) + XSUM_W'(prod_q[c][2])
               + (XSUM_W'(tr_q[c]) <<< 16) + XSUM_W'(RND_Q16);
      res_d[c] = sat32(64'(sum_d[c] >>> 16));
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/lbs_lane.sv =====
module lbs_lane #(
  parameter int JOINT_COUNT = 64,
  parameter int AW          = 6
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic [3:0]                          wr_el_i,
  input  logic signed [lbs_pkg::WORD_W-1:0]   wr_data_i,
  input  logic                                rd_en_i,
  input  logic [AW-1:0]                       rd_addr_i,
  input  logic                                hold_en_i,
  input  logic                                prod_en_i,
  input  logic                                sum_en_i,
  input  logic                                wgt_en_i,
  input  logic                                with_t_i,
  input  logic signed [lbs_pkg::WORD_W-1:0]   vec_i [3],
  input  logic                                lane_on_i,
  input  logic signed [lbs_pkg::WGT_W-1:0]    weight_i,
  output logic signed [lbs_pkg::WPROD_W-1:0]  wsum_o [3]
);
  import lbs_pkg::*;

  logic signed [WORD_W-1:0]  rd_q [MAT_WORDS];
  logic signed [WORD_W-1:0]  jw_q [MAT_WORDS];
  logic signed [WORD_W-1:0]  q_res [3];
  logic signed [WPROD_W-1:0] wp_q [3];

  // one memory per matrix element, so all words of a matrix are read together
  for (genvar e = 0; e < MAT_WORDS; e++) begin : g_elem
    logic signed [WORD_W-1:0] mem [JOINT_COUNT];
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_el_i == 4'(e))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q[e] <= mem[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_en_i) begin
      jw_q <= rd_q;
    end
  end

  lbs_xform u_xform (
    .clk_i     (clk_i),
    .prod_en_i (prod_en_i),
    .sum_en_i  (sum_en_i),
    .with_t_i  (with_t_i),
    .mat_i     (jw_q),
    .vec_i     (vec_i),
    .res_o     (q_res)
  );

  always_ff @(posedge clk_i) begin
    if (wgt_en_i) begin
      for (int c = 0; c < 3; c++) begin
        wp_q[c] <= lane_on_i ? q_res[c] * weight_i : WPROD_W'(0);
      end
    end
  end

  assign wsum_o = wp_q;

endmodule

// ===== design/lbs_merge.sv =====
module lbs_merge #(
  parameter int LANES = 4
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic                                pass_i,
  input  logic                                fault_i,
  input  logic signed [lbs_pkg::WORD_W-1:0]   vec_i [3],
  input  logic signed [lbs_pkg::WPROD_W-1:0]  wsum_i [LANES][3],
  output lbs_pkg::rsp_t                       rsp_o
);
  import lbs_pkg::*;

  logic signed [MSUM_W-1:0] sum_d [3];
  logic signed [WORD_W-1:0] blend_d [3];
  rsp_t                     rsp_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = MSUM_W'(RND_Q15);
      for (int l = 0; l < LANES; l++) begin
        sum_d[c] = sum_d[c] + MSUM_W'(wsum_i[l][c]);
      end
      blend_d[c] = pass_i ? vec_i[c] : sat32(64'(sum_d[c] >>> 15));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q.out_x       <= blend_d[0];
      rsp_q.out_y       <= blend_d[1];
      rsp_q.out_z       <= blend_d[2];
      rsp_q.joint_fault <= fault_i;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== design/linear_blend_skinning_unit.sv =====
// channel   dir   handshake                   payload
// in        in    in_valid_i / in_ready_o     in_req_i (matrix word write or vertex request)
// out       out   out_valid_o / out_ready_i   out_rsp_o (skinned vertex and fault flag)
// cfg       in    cfg_valid_i / cfg_ready_o   cfg_influences_i (influences per vertex)
//
// one request per cycle while in_ready_o is high; out_ready_i low stalls the pipe
// a vertex passes through the chain bind product, bind sum, joint product, joint sum,
// weight product, lane merge; each stage holds its own product or sum register
// every stage advances when the stage after it is empty or moving, so bubbles close up
// reset clears stage valids and the influences register; the matrix store is not cleared
module linear_blend_skinning_unit #(
  parameter int JOINT_COUNT    = 64,
  parameter int MAX_INFLUENCES = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lbs_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lbs_pkg::rsp_t  out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_influences_i
);
  import lbs_pkg::*;

  localparam int AW     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int STAGES = 6;

  // sideband that travels with a vertex through the pipe
  typedef struct packed {
    logic                     point;
    logic                     pass;
    logic                     fault;
    logic [LANE_MAX-1:0]      lane_on;
    logic [63:0]              weights;
    logic signed [WORD_W-1:0] vx;
    logic signed [WORD_W-1:0] vy;
    logic signed [WORD_W-1:0] vz;
  } ctl_t;

  logic [2:0]            influences_q;
  logic [2:0]            n_used;
  logic [STAGES:1]       v_q;
  logic [STAGES:1]       en;
  ctl_t                  ctl_q [1:STAGES-1];
  ctl_t                  ctl_d;
  logic                  skin_acc;
  logic                  wr_acc;
  logic                  joint_wr;
  logic                  bind_wr;
  logic [AW-1:0]         wr_addr;
  logic signed [WORD_W-1:0] bind_q [MAT_WORDS];
  logic signed [WORD_W-1:0] vec_in [3];
  logic signed [WORD_W-1:0] bind_res [3];
  logic signed [WORD_W-1:0] pass_vec [3];
  logic signed [WPROD_W-1:0] wsum [MAX_INFLUENCES][3];
  logic [LANE_MAX-1:0]   used;
  logic [LANE_MAX-1:0]   bad;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      influences_q <= '0;
    end else if (cfg_valid_i) begin
      influences_q <= cfg_influences_i;
    end
  end

  assign n_used = (influences_q > 3'(MAX_INFLUENCES)) ? 3'(MAX_INFLUENCES) : influences_q;

  // stage enables: a stage loads when empty or when its contents move on
  always_comb begin
    en[STAGES] = !v_q[STAGES] || out_ready_i;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1];
  assign skin_acc   = in_valid_i && en[1] &&
                      ((in_req_i.operation == OP_POINT) || (in_req_i.operation == OP_DIR));
  assign wr_acc     = in_valid_i && en[1] && (in_req_i.operation == OP_WRITE);

  // matrix word writes: joint slots go to the lane memories, slot JOINT_COUNT to bind_q
  assign joint_wr = wr_acc && ({1'b0, in_req_i.matrix_slot} < 8'(JOINT_COUNT)) &&
                    (in_req_i.matrix_element < 4'(MAT_WORDS));
  assign bind_wr  = wr_acc && ({1'b0, in_req_i.matrix_slot} == 8'(JOINT_COUNT)) &&
                    (in_req_i.matrix_element < 4'(MAT_WORDS));
  assign wr_addr  = AW'({1'b0, in_req_i.matrix_slot});

  always_ff @(posedge clk_i) begin
    if (bind_wr) begin
      bind_q[in_req_i.matrix_element] <= in_req_i.in_x;
    end
  end

  // per-lane use and fault decode at the input
  always_comb begin
    for (int l = 0; l < LANE_MAX; l++) begin
      used[l] = (l < MAX_INFLUENCES) && (3'(l) < n_used);
      bad[l]  = in_req_i.joint_ids[8*l +: 8] >= 8'(JOINT_COUNT);
    end
    ctl_d.point   = (in_req_i.operation == OP_POINT);
    ctl_d.pass    = (n_used == 3'd0);
    ctl_d.fault   = |(used & bad);
    ctl_d.lane_on = used & ~bad;
    ctl_d.weights = in_req_i.joint_weight_set;
    ctl_d.vx      = in_req_i.in_x;
    ctl_d.vy      = in_req_i.in_y;
    ctl_d.vz      = in_req_i.in_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= skin_acc;
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) ctl_q[1] <= ctl_d;
    for (int k = 2; k <= STAGES - 1; k++) begin
      if (en[k]) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // bind transform: products straight off the request, sum in stage 2
  assign vec_in[0] = in_req_i.in_x;
  assign vec_in[1] = in_req_i.in_y;
  assign vec_in[2] = in_req_i.in_z;

  lbs_xform u_bind (
    .clk_i     (clk_i),
    .prod_en_i (en[1]),
    .sum_en_i  (en[2]),
    .with_t_i  (in_req_i.operation == OP_POINT),
    .mat_i     (bind_q),
    .vec_i     (vec_in),
    .res_o     (bind_res)
  );

  // one joint lane per influence, each with its own copy of the joint matrices
  for (genvar l = 0; l < MAX_INFLUENCES; l++) begin : g_lane
    lbs_lane #(
      .JOINT_COUNT (JOINT_COUNT),
      .AW          (AW)
    ) u_lane (
      .clk_i     (clk_i),
      .wr_en_i   (joint_wr),
      .wr_addr_i (wr_addr),
      .wr_el_i   (in_req_i.matrix_element),
      .wr_data_i (in_req_i.in_x),
      .rd_en_i   (en[1]),
      .rd_addr_i (AW'(in_req_i.joint_ids[8*l +: 8])),
      .hold_en_i (en[2]),
      .prod_en_i (en[3]),
      .sum_en_i  (en[4]),
      .wgt_en_i  (en[5]),
      .with_t_i  (ctl_q[2].point),
      .vec_i     (bind_res),
      .lane_on_i (ctl_q[4].lane_on[l]),
      .weight_i  (ctl_q[4].weights[16*l +: 16]),
      .wsum_o    (wsum[l])
    );
  end

  // unskinned vertex for the pass-through case
  assign pass_vec[0] = ctl_q[STAGES-1].vx;
  assign pass_vec[1] = ctl_q[STAGES-1].vy;
  assign pass_vec[2] = ctl_q[STAGES-1].vz;

  // merge of the lane results, also the output register
  lbs_merge #(
    .LANES (MAX_INFLUENCES)
  ) u_merge (
    .clk_i   (clk_i),
    .en_i    (en[STAGES]),
    .pass_i  (ctl_q[STAGES-1].pass),
    .fault_i (ctl_q[STAGES-1].fault),
    .vec_i   (pass_vec),
    .wsum_i  (wsum),
    .rsp_o   (out_rsp_o)
  );

  assign out_valid_o = v_q[STAGES];

`ifndef SYNTH
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_acc |=> !v_q[1])
    else $error("matrix write entered the pipe");

  a_result_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v_q[STAGES-1]))
    else $error("result without a vertex in flight");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v_q[1] && out_valid_o && !out_ready_i))
    else $error("input stalled with room in the pipe");
`endif

endmodule
